/* design/sorted_key_table_engine_macros.svh */
// ---------------------------------------------------------------------------
// sorted key table engine assertion macros
// shared concurrent assertion forms, clocked and disabled in reset
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_ENGINE_MACROS_SVH
`define SORTED_KEY_TABLE_ENGINE_MACROS_SVH

// same-cycle implication
`define SKTE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define SKTE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* design/skte_pkg.sv */
// ---------------------------------------------------------------------------
// skte_pkg
// types and fixed constants of the sorted key table engine
// ---------------------------------------------------------------------------
package skte_pkg;

  localparam int KEY_W    = 16;
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 8;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 9;

  // built table depth and its slot address width
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;
  localparam int REG_IDX_W = 1;

  // register word indexes
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEARCH = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE      = 3'd0,
    STS_NOT_FOUND = 3'd1,
    STS_FULL      = 3'd2,
    STS_PRESENT   = 3'd3,
    STS_ZERO_KEY  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_READ,
    S_TAIL,
    S_TAIL_LD,
    S_RESP
  } state_t;

endpackage

/* design/skte_if.sv */
// ---------------------------------------------------------------------------
// skte stream interfaces
// request and result channels, valid/ready handshake
// ---------------------------------------------------------------------------
interface skte_in_if import skte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [IDX_W-1:0]  index;

  modport source (output valid, func, key, index, input ready);
  modport sink   (input valid, func, key, index, output ready);
endinterface

interface skte_out_if import skte_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [KEY_W-1:0]    read_key;
  logic [CNT_W-1:0]    entry_count;
  logic [KEY_W-1:0]    largest_key;

  modport source (output valid, status, position, read_key, entry_count, largest_key,
                  input ready);
  modport sink   (input valid, status, position, read_key, entry_count, largest_key,
                  output ready);
endinterface

/* design/skte_ram.sv */
// ---------------------------------------------------------------------------
// skte_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module skte_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/skte_cfg.sv */
// ---------------------------------------------------------------------------
// skte_cfg
// apb register file: capacity in use
// ---------------------------------------------------------------------------
module skte_cfg import skte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [CNT_W-1:0]  capacity
);

  logic [CNT_W-1:0]     cap_r;
  logic [REG_IDX_W-1:0] word_idx;
  logic                 wr_cap;

  // byte address to register word
  assign word_idx = paddr[CFG_AW-1:2];
  assign wr_cap   = psel && penable && pwrite && (word_idx == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (wr_cap) begin
      cap_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata   = (word_idx == REG_CAPACITY) ? CFG_DW'(cap_r) : '0;
  assign pready   = 1'b1;
  assign capacity = cap_r;

endmodule

/* design/skte_ctrl.sv */
// ---------------------------------------------------------------------------
// skte_ctrl
// sequencer: binary search, shift up/down through the key ram, result register
// ---------------------------------------------------------------------------
`include "sorted_key_table_engine_macros.svh"

module skte_ctrl import skte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  capacity,
  skte_in_if.sink           in_if,
  skte_out_if.source        out_if,
  output logic              ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output logic [KEY_W-1:0]  ram_wr_data,
  output logic              ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr,
  input  logic [KEY_W-1:0]  ram_rd_data
);

  state_t             state_r, state_nxt;
  func_t              func_r, func_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic [CNT_W-1:0]   mid_r, mid_nxt;
  logic               hit_r, hit_nxt;
  logic [CNT_W-1:0]   sh_i_r, sh_i_nxt;
  logic               pend_r, pend_nxt;
  logic [CNT_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [KEY_W-1:0]   largest_r, largest_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [POS_W-1:0]   res_pos_r, res_pos_nxt;
  logic [KEY_W-1:0]   res_rkey_r, res_rkey_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [KEY_W-1:0]   out_rkey_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [KEY_W-1:0]   out_large_r;
  logic               load_out;

  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   cap_lim;
  logic [CNT_W-1:0]   cap_eff;
  logic               full;
  logic [CNT_W-1:0]   in_idx;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign cap_lim = (32'(capacity) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : capacity;
  assign cap_eff = (capacity == '0) ? CNT_W'(1) : cap_lim;
  assign full    = count_r >= cap_eff;
  assign in_idx  = CNT_W'(in_if.index);

  assign in_if.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    hit_nxt        = hit_r;
    sh_i_nxt       = sh_i_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    count_nxt      = count_r;
    largest_nxt    = largest_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    res_rkey_nxt   = res_rkey_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = '0;
    ram_wr_data    = '0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = '0;
    load_out       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          func_nxt       = func_t'(in_if.func);
          key_nxt        = in_if.key;
          lo_nxt         = '0;
          hi_nxt         = count_r;
          hit_nxt        = 1'b0;
          res_status_nxt = STS_DONE;
          res_pos_nxt    = '0;
          res_rkey_nxt   = '0;
          if (func_t'(in_if.func) == FUNC_READ) begin
            if (in_idx < count_r) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = ADDR_W'(in_if.index);
              res_pos_nxt = in_if.index;
              state_nxt   = S_READ;
            end else begin
              res_status_nxt = STS_NOT_FOUND;
              state_nxt      = S_RESP;
            end
          end else if (in_if.key == '0) begin
            res_status_nxt = (func_t'(in_if.func) == FUNC_INSERT) ? STS_ZERO_KEY
                                                                   : STS_NOT_FOUND;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (lo_r < hi_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ADDR_W'(mid);
          mid_nxt     = mid;
          state_nxt   = S_CMP;
        end else begin
          // lo_r is the lower bound, hit_r tells whether it holds the key
          case (func_r)
            FUNC_SEARCH: begin
              res_status_nxt = hit_r ? STS_DONE : STS_NOT_FOUND;
              res_pos_nxt    = hit_r ? POS_W'(lo_r) : '0;
              state_nxt      = S_RESP;
            end
            FUNC_INSERT: begin
              if (hit_r) begin
                res_status_nxt = STS_PRESENT;
                res_pos_nxt    = POS_W'(lo_r);
                state_nxt      = S_RESP;
              end else if (full) begin
                res_status_nxt = STS_FULL;
                state_nxt      = S_RESP;
              end else begin
                res_pos_nxt = POS_W'(lo_r);
                sh_i_nxt    = count_r;
                pend_nxt    = 1'b0;
                state_nxt   = S_SHIFT_UP;
              end
            end
            FUNC_DELETE: begin
              if (hit_r) begin
                res_pos_nxt = POS_W'(lo_r);
                sh_i_nxt    = lo_r;
                pend_nxt    = 1'b0;
                state_nxt   = S_SHIFT_DN;
              end else begin
                res_status_nxt = STS_NOT_FOUND;
                state_nxt      = S_RESP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_CMP: begin
        if (ram_rd_data < key_r) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt  = mid_r;
          hit_nxt = (ram_rd_data == key_r);
        end
        state_nxt = S_PROBE;
      end

      S_SHIFT_UP: begin
        // read slot i-1 while the slot read last cycle lands one above it
        if (pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ADDR_W'(pend_addr_r);
          ram_wr_data = ram_rd_data;
        end
        if (sh_i_r > lo_r) begin
          ram_rd_en     = 1'b1;
          ram_rd_addr   = ADDR_W'(sh_i_r - CNT_W'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = sh_i_r;
          sh_i_nxt      = sh_i_r - CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(lo_r);
            ram_wr_data = key_r;
            count_nxt   = count_r + CNT_W'(1);
            state_nxt   = S_TAIL;
          end
        end
      end

      S_SHIFT_DN: begin
        if (pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ADDR_W'(pend_addr_r);
          ram_wr_data = ram_rd_data;
        end
        if ((sh_i_r + CNT_W'(1)) < count_r) begin
          ram_rd_en     = 1'b1;
          ram_rd_addr   = ADDR_W'(sh_i_r + CNT_W'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = sh_i_r;
          sh_i_nxt      = sh_i_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_TAIL;
          end
        end
      end

      S_READ: begin
        res_rkey_nxt = ram_rd_data;
        state_nxt    = S_RESP;
      end

      S_TAIL: begin
        if (count_r != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ADDR_W'(count_r - CNT_W'(1));
        end
        state_nxt = S_TAIL_LD;
      end

      S_TAIL_LD: begin
        largest_nxt = (count_r != '0) ? ram_rd_data : '0;
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      largest_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      largest_r   <= largest_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    hit_r        <= hit_nxt;
    sh_i_r       <= sh_i_nxt;
    pend_addr_r  <= pend_addr_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    res_rkey_r   <= res_rkey_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_rkey_r   <= res_rkey_r;
      out_cnt_r    <= count_r;
      out_large_r  <= largest_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.position    = out_pos_r;
  assign out_if.read_key    = out_rkey_r;
  assign out_if.entry_count = out_cnt_r;
  assign out_if.largest_key = out_large_r;

  // stored count never exceeds the built depth
  `SKTE_ASSERT_IMP(a_count_le_depth, clk, rst_n, 1'b1, 32'(count_r) <= TABLE_DEPTH)

  // search window stays ordered and within the stored keys
  `SKTE_ASSERT_IMP(a_window_ok, clk, rst_n, (state_r == S_PROBE) || (state_r == S_CMP),
                   (lo_r <= hi_r) && (hi_r <= count_r))

  // shifts never write past the first free slot
  `SKTE_ASSERT_IMP(a_wr_in_range, clk, rst_n, ram_wr_en, 32'(ram_wr_addr) <= 32'(count_r))

  // a probe read is always followed by its compare
  `SKTE_ASSERT_NXT(a_probe_cmp, clk, rst_n, (state_r == S_PROBE) && ram_rd_en,
                   state_r == S_CMP)

endmodule

/* design/sorted_key_table_engine.sv */
// ---------------------------------------------------------------------------
// sorted_key_table_engine
// ascending table of distinct nonzero keys: search, insert, delete, read
// ---------------------------------------------------------------------------
//
//   channel   | dir | handshake            | payload
//   ----------+-----+----------------------+----------------------------------
//   in_if     | in  | valid/ready          | func, key, index
//   out_if    | out | valid/ready          | status, position, read_key,
//             |     |                      | entry_count, largest_key
//   apb       | in  | psel/penable, pready | paddr, pwdata, prdata
//
// one request beat at a time; the result register frees the request side, so the
// next beat is taken while a finished result still waits on out_if
// search: each probe of the binary search is a ram read then a compare,
// with probes near log2(count+1)
// insert/delete: search, then one slot per cycle through the key ram port pair
// (count - position slots on insert, count - position - 1 on delete), then a
// read of the top slot refreshes the largest key
// read at index: one ram read of the indexed slot, checked against the count
// reset clears the count, largest key and control state, not the ram; entries
// above the count are never read: no clearing pass, beats taken right after reset
// ---------------------------------------------------------------------------
module sorted_key_table_engine import skte_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  skte_in_if.sink           in_if,
  skte_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // capacity register, clamped inside the sequencer
  logic [CNT_W-1:0] capacity;

  // key ram ports
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [KEY_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [KEY_W-1:0]  ram_rd_data;

  skte_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // sequencer: search probes, shifts and the result register
  skte_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .capacity    (capacity),
    .in_if       (in_if),
    .out_if      (out_if),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // key slots, one key per entry, ascending from entry zero
  skte_ram #(
    .DATA_W (KEY_W),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

/* dv/sorted_key_table_engine_tb.sv */
// ---------------------------------------------------------------------------
// sorted_key_table_engine_tb
// self-checking bench: request beats from a queue, a local table model
// predicts every reply, the reply monitor compares field by field; random
// idle on both channels and capacity changes over apb between phases
// ---------------------------------------------------------------------------
module sorted_key_table_engine_tb import skte_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // margin over the worst insert or delete
  localparam int DRAIN_CYCLES = 320;

  localparam logic [CFG_AW-1:0] CAP_ADDR        = {REG_CAPACITY, 2'b00};
  // word index 1 has no register behind it
  localparam logic [CFG_AW-1:0] UNUSED_REG_ADDR = 3'd4;

  typedef struct {
    func_t            func;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] index;
  } table_request_t;

  typedef struct {
    status_t             status;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    read_key;
    logic [CNT_W-1:0]    entry_count;
    logic [KEY_W-1:0]    largest_key;
  } table_reply_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  skte_in_if  req_if ();
  skte_out_if rsp_if ();

  sorted_key_table_engine dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (req_if),
    .out_if  (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the key table, advanced once per accepted request beat
  logic [KEY_W-1:0] model_keys [0:TABLE_DEPTH-1];
  int               model_count;
  logic [CNT_W-1:0] model_capacity;
  int               peak_count;

  table_request_t queued_requests[$];
  table_reply_t   pending_replies[$];

  int  mismatches;
  int  beats_sent;
  int  replies_seen;
  int  cap_writes;
  int  status_tally [0:4];
  int  send_gap;
  int  hold_left;
  bit  sender_calm;
  bit  receiver_calm;

  // -------------------------------------------------------------------------
  // table model: binary search for the first slot not below the key, then
  // shift up on insert or down on delete
  // -------------------------------------------------------------------------
  function automatic table_reply_t apply_table_request(func_t f, logic [KEY_W-1:0] k,
                                                       logic [IDX_W-1:0] ix);
    table_reply_t r;
    int lo;
    int hi;
    int mid;
    int eff_cap;
    bit hit;
    r.status   = STS_DONE;
    r.position = '0;
    r.read_key = '0;
    // zero acts as one slot, anything past the built depth as the full depth
    if (model_capacity == 0) eff_cap = 1;
    else if (model_capacity > TABLE_DEPTH) eff_cap = TABLE_DEPTH;
    else eff_cap = int'(model_capacity);

    if (f == FUNC_READ) begin
      if (ix < model_count) begin
        r.read_key = model_keys[ix];
        r.position = ix;
      end else begin
        r.status = STS_NOT_FOUND;
      end
    end else if (k == '0) begin
      // zero is never stored: insert rejects it, search and delete miss
      r.status = (f == FUNC_INSERT) ? STS_ZERO_KEY : STS_NOT_FOUND;
    end else begin
      lo = 0;
      hi = model_count;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (model_keys[mid] < k) lo = mid + 1;
        else hi = mid;
      end
      hit = (lo < model_count) && (model_keys[lo] == k);
      case (f)
        FUNC_SEARCH: begin
          if (hit) r.position = POS_W'(lo);
          else r.status = STS_NOT_FOUND;
        end
        FUNC_INSERT: begin
          // duplicate check wins over the full check
          if (hit) begin
            r.status   = STS_PRESENT;
            r.position = POS_W'(lo);
          end else if (model_count >= eff_cap) begin
            r.status = STS_FULL;
          end else begin
            for (int i = model_count; i > lo; i--) model_keys[i] = model_keys[i-1];
            model_keys[lo] = k;
            model_count++;
            r.position = POS_W'(lo);
          end
        end
        default: begin
          if (hit) begin
            for (int i = lo; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
            model_keys[model_count-1] = '0;
            model_count--;
            r.position = POS_W'(lo);
          end else begin
            r.status = STS_NOT_FOUND;
          end
        end
      endcase
    end
    if (model_count > peak_count) peak_count = model_count;
    r.entry_count = CNT_W'(model_count);
    r.largest_key = (model_count > 0) ? model_keys[model_count-1] : '0;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // clock, reset and known levels on every input from time zero
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.func   = FUNC_SEARCH;
    req_if.key    = '0;
    req_if.index  = '0;
    rsp_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) model_keys[i] = '0;
    model_count    = 0;
    model_capacity = CAP_RESET;
    peak_count     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // -------------------------------------------------------------------------
  // request driver: one beat in flight, random gap before each beat; the
  // reply is predicted at the edge the beat is taken
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    table_request_t rq;
    table_reply_t   rp;
    bit             vld_nxt;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      vld_nxt = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        rp = apply_table_request(func_t'(req_if.func), req_if.key, req_if.index);
        pending_replies.push_back(rp);
        beats_sent++;
        // every so often switch between idle-heavy and back-to-back stretches
        if (beats_sent % 25 == 0) sender_calm = ($urandom_range(0, 3) == 0);
        send_gap = sender_calm ? 0 : $urandom_range(0, 14);
        vld_nxt  = 1'b0;
      end
      if (!vld_nxt) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (queued_requests.size() > 0) begin
          rq = queued_requests.pop_front();
          req_if.func  <= rq.func;
          req_if.key   <= rq.key;
          req_if.index <= rq.index;
          vld_nxt = 1'b1;
        end
      end
      // single update of valid per edge, so a held beat never blinks
      req_if.valid <= vld_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // reply monitor: random back-pressure, compare against the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    table_reply_t want;
    bit           bad;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        replies_seen++;
        if (rsp_if.status <= STS_ZERO_KEY) status_tally[rsp_if.status]++;
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] reply beat with nothing outstanding: sts=%0d pos=%0d", $realtime,
                     rsp_if.status, rsp_if.position);
        end else begin
          want = pending_replies.pop_front();
          bad  = (rsp_if.status      !== want.status)      ||
                 (rsp_if.position    !== want.position)    ||
                 (rsp_if.read_key    !== want.read_key)    ||
                 (rsp_if.entry_count !== want.entry_count) ||
                 (rsp_if.largest_key !== want.largest_key);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] reply %0d differs", $realtime, replies_seen);
              $display("  expected sts=%0d pos=%0d rkey=%h cnt=%0d max=%h", want.status,
                       want.position, want.read_key, want.entry_count, want.largest_key);
              $display("  actual   sts=%0d pos=%0d rkey=%h cnt=%0d max=%h", rsp_if.status,
                       rsp_if.position, rsp_if.read_key, rsp_if.entry_count,
                       rsp_if.largest_key);
            end
          end
        end
        if (replies_seen % 25 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
        hold_left = receiver_calm ? 0 : $urandom_range(0, 14);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      rsp_if.ready <= (hold_left == 0);
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  task automatic apb_access(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // block must be idle: no queued beat, none on the wire, no reply owed;
  // sampled mid-cycle so a beat popped at the last edge is already visible
  task automatic wait_idle();
    do @(negedge clk);
    while (queued_requests.size() != 0 || req_if.valid || pending_replies.size() != 0);
  endtask

  // write the capacity and read it back
  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    logic [CFG_DW-1:0] rd;
    wait_idle();
    apb_access(1'b1, CAP_ADDR, CFG_DW'(cap), rd);
    model_capacity = cap;
    cap_writes++;
    apb_access(1'b0, CAP_ADDR, '0, rd);
    if (rd[CNT_W-1:0] !== cap) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] capacity readback expected %0d actual %0d", $realtime, cap,
                 rd[CNT_W-1:0]);
    end
  endtask

  // keep at most one beat queued so random picks see a fresh table model
  task automatic post(input func_t f, input logic [KEY_W-1:0] k, input logic [IDX_W-1:0] ix);
    table_request_t rq;
    while (queued_requests.size() != 0) @(posedge clk);
    rq.func  = f;
    rq.key   = k;
    rq.index = ix;
    queued_requests.push_back(rq);
  endtask

  // random mix: a share of keys set by hit_pct are stored ones (hits), some from a narrow pool,
  // the rest anywhere in the 16-bit range including zero
  task automatic run_phase(input logic [CNT_W-1:0] cap, input int n, input int ins_pct,
                           input int del_pct, input int hit_pct, input int pool_max);
    func_t            f;
    logic [KEY_W-1:0] k;
    logic [IDX_W-1:0] ix;
    int               r;
    set_capacity(cap);
    for (int j = 0; j < n; j++) begin
      while (queued_requests.size() != 0) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r < ins_pct) f = FUNC_INSERT;
      else if (r < ins_pct + del_pct) f = FUNC_DELETE;
      else if (r % 2 == 0) f = FUNC_SEARCH;
      else f = FUNC_READ;
      r = $urandom_range(0, 99);
      if (r < 3) k = '0;
      else if (r < 3 + hit_pct && model_count > 0)
        k = model_keys[$urandom_range(0, model_count - 1)];
      else if (r % 3 == 0) k = KEY_W'($urandom_range(1, pool_max));
      else k = KEY_W'($urandom_range(0, 65535));
      if ($urandom_range(0, 9) < 7 && model_count > 0)
        ix = IDX_W'($urandom_range(0, model_count - 1));
      else ix = IDX_W'($urandom_range(0, 255));
      post(f, k, ix);
      // occasional full drain in the middle of a phase
      if ($urandom_range(0, 99) == 0) wait_idle();
    end
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [CFG_DW-1:0] rd;
    do @(posedge clk); while (!rst_n);

    // directed: empty table, zero key, extremes, duplicates, shifts both ways
    post(FUNC_READ,   16'h0000, 8'd0);     // read on empty table
    post(FUNC_SEARCH, 16'h0000, 8'd0);     // search for zero
    post(FUNC_DELETE, 16'h1234, 8'd0);     // delete on empty table
    post(FUNC_INSERT, 16'h0000, 8'd0);     // zero key rejected
    post(FUNC_INSERT, 16'hFFFF, 8'd0);
    post(FUNC_INSERT, 16'h0001, 8'd0);     // goes below, shifts the top key up
    post(FUNC_INSERT, 16'h8000, 8'd0);     // lands in the middle
    post(FUNC_INSERT, 16'h8000, 8'd0);     // already present
    post(FUNC_SEARCH, 16'h8000, 8'd0);
    post(FUNC_SEARCH, 16'h7FFF, 8'd0);     // missing key
    post(FUNC_READ,   16'h0000, 8'd2);
    post(FUNC_READ,   16'h0000, 8'd3);     // just past the stored keys
    post(FUNC_READ,   16'hFFFF, 8'd255);   // top index
    post(FUNC_DELETE, 16'h0000, 8'd0);     // delete of zero misses
    post(FUNC_DELETE, 16'h0001, 8'd0);     // lowest, everything shifts down
    post(FUNC_DELETE, 16'hFFFF, 8'd0);     // largest key changes
    post(FUNC_DELETE, 16'h8000, 8'd0);     // table empty again
    post(FUNC_INSERT, 16'h5555, 8'd0);
    post(FUNC_INSERT, 16'hAAAA, 8'd0);

    // capacity below the count: nothing dropped, inserts see full
    set_capacity(9'd1);
    post(FUNC_INSERT, 16'h1234, 8'd0);
    post(FUNC_INSERT, 16'h5555, 8'd0);     // duplicate check comes first
    post(FUNC_SEARCH, 16'hAAAA, 8'd0);

    // capacity zero behaves as one; a write to the unused word changes nothing
    set_capacity(9'd0);
    wait_idle();
    apb_access(1'b1, UNUSED_REG_ADDR, 32'h0000_01FF, rd);
    post(FUNC_DELETE, 16'h5555, 8'd0);
    post(FUNC_INSERT, 16'h0002, 8'd0);     // count 1 against one slot: full

    // all ones in the register clamps to the built depth
    set_capacity(9'd511);
    post(FUNC_INSERT, 16'h0002, 8'd0);

    // random phases: small capacity, zero, a fill to the top, work on the
    // full table, capacity under the count, then over the depth
    run_phase(9'd3,   60,  40, 25, 50, 16);
    run_phase(9'd0,   25,  50, 25, 50, 16);
    run_phase(9'd256, 300, 95, 2,  10, 65535);
    run_phase(9'd511, 120, 20, 40, 70, 65535);
    run_phase(9'd200, 150, 15, 70, 85, 65535);
    run_phase(9'd1,   30,  60, 10, 50, 65535);
    run_phase(9'd300, 100, 35, 30, 50, 64);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d request beats under %0d capacity writes, peak fill %0d of %0d",
             beats_sent, cap_writes, peak_count, TABLE_DEPTH);
    $display("reply statuses: done %0d, not found %0d, full %0d, present %0d, zero key %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #10ms;
    $display("timeout with %0d replies outstanding", pending_replies.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
